FILE: src/gcke_pkg.sv
`timescale 1ns / 1ps
package gcke_pkg;
    localparam int MAX_SPAN  = 4;
    localparam int SPAN_W    = 2;
    localparam int COORD_W   = 32;
    localparam int CSIZE_W   = 31;
    localparam int KEY_W     = 64;
    localparam logic [31:0] HASH_PX = 32'd73856093;
    localparam logic [31:0] HASH_PY = 32'd19349663;
    localparam logic [31:0] HASH_PZ = 32'd83492791;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_HASH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic bounds_latch;
        logic hash_start;
        logic advance;
    } ctrl_t;

    typedef struct packed {
        logic div_done;
        logic empty;
        logic hash_done;
        logic last;
    } stat_t;
endpackage

FILE: src/gcke_div.sv
`timescale 1ns / 1ps
module gcke_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [31:0]           dividend,
    input  logic [30:0]                  divisor,
    output logic                         done,
    output logic signed [31:0]           quotient
);
    import gcke_pkg::*;

    // restoring divide of |a| by d, one bit per cycle, then floor correction
    logic [31:0] mag_reg, mag_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [30:0] d_eff;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic [32:0] qn;

    assign d_eff = (divisor == '0) ? 31'd1 : divisor;

    always_comb
    begin
        rem_sh    = {rem_reg[30:0], mag_reg[31]};
        trial     = {1'b0, rem_sh} - {2'b0, d_eff};
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        qn        = '0;
        if (start)
        begin
            mag_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            neg_next  = dividend[31];
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[30:0], 1'b0};
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                begin
                    qn = 33'd0 - {1'b0, q_next};
                    if (rem_next != '0)
                        qn = qn - 33'd1;
                    q_next = qn[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

FILE: src/gcke_datapath.sv
`timescale 1ns / 1ps
module gcke_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  gcke_pkg::ctrl_t   ctrl,
    output gcke_pkg::stat_t   stat,
    input  logic [191:0]      box,
    input  logic [30:0]       pitch,
    output logic [63:0]       cell_key,
    output logic [31:0]       cell_x,
    output logic [31:0]       cell_y,
    output logic [31:0]       cell_z,
    output logic              clipped
);
    import gcke_pkg::*;

    logic [191:0] box_reg;
    logic [2:0]   idx_reg, idx_next;
    logic signed [31:0] q [0:5];
    logic signed [31:0] lo_reg [0:2];
    logic signed [31:0] pos_reg [0:2];
    logic [SPAN_W-1:0]  off_reg [0:2];
    logic [SPAN_W-1:0]  lim_reg [0:2];
    logic         clip_reg;
    logic         empty_c, clip_c;
    logic [SPAN_W-1:0] lim_c [0:2];
    logic         dstart, ddone;
    logic signed [31:0] dq;
    logic signed [31:0] dvd;
    logic         run_reg;
    logic [1:0]   hph_reg;
    logic         hdone_reg;
    logic [63:0]  prod_reg [0:2];
    logic signed [65:0] px_full, py_full, pz_full;
    logic [63:0]  mx, my, mz;
    logic         end_x, end_y, end_z;

    gcke_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart),
        .dividend(dvd), .divisor(pitch),
        .done(ddone), .quotient(dq)
    );

    // six divisions back to back; control starts the first
    assign dstart = ctrl.div_start || (run_reg && ddone && idx_reg != 3'd5);

    // first division reads the request directly, later ones the next coordinate
    assign idx_next = idx_reg + 3'd1;

    always_comb
    begin
        dvd = box[31:0];
        if (!ctrl.div_start)
        begin
            case (idx_next)
                3'd1:    dvd = box_reg[63:32];
                3'd2:    dvd = box_reg[95:64];
                3'd3:    dvd = box_reg[127:96];
                3'd4:    dvd = box_reg[159:128];
                3'd5:    dvd = box_reg[191:160];
                default: dvd = box_reg[31:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            run_reg   <= 1'b0;
            hph_reg   <= '0;
            hdone_reg <= 1'b0;
        end
        else
        begin
            hdone_reg <= 1'b0;
            if (ctrl.div_start)
            begin
                idx_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg && ddone)
            begin
                if (idx_reg == 3'd5)
                    run_reg <= 1'b0;
                else
                    idx_reg <= idx_next;
            end
            if (ctrl.hash_start)
                hph_reg <= 2'd1;
            else if (hph_reg == 2'd1)
                hph_reg <= 2'd2;
            else if (hph_reg == 2'd2)
            begin
                hph_reg   <= 2'd0;
                hdone_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            box_reg <= box;
        if (run_reg && ddone)
            q[idx_reg] <= dq;
    end

    always_comb
    begin
        logic signed [32:0] diff;
        empty_c = 1'b0;
        clip_c  = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            diff = {q[i+3][31], q[i+3]} - {q[i][31], q[i]};
            lim_c[i] = diff[SPAN_W-1:0];
            if (diff < 0)
                empty_c = 1'b1;
            else if (diff > 33'(MAX_SPAN - 1))
            begin
                clip_c   = 1'b1;
                lim_c[i] = SPAN_W'(MAX_SPAN - 1);
            end
        end
    end

    assign end_x = off_reg[0] == lim_reg[0];
    assign end_y = off_reg[1] == lim_reg[1];
    assign end_z = off_reg[2] == lim_reg[2];

    always_ff @(posedge clk)
    begin
        if (ctrl.bounds_latch)
        begin
            clip_reg <= clip_c;
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i]  <= q[i];
                lim_reg[i] <= lim_c[i];
                pos_reg[i] <= q[i];
                off_reg[i] <= '0;
            end
        end
        else if (ctrl.advance)
        begin
            if (!end_z)
            begin
                pos_reg[2] <= pos_reg[2] + 32'd1;
                off_reg[2] <= off_reg[2] + 1'b1;
            end
            else
            begin
                pos_reg[2] <= lo_reg[2];
                off_reg[2] <= '0;
                if (!end_y)
                begin
                    pos_reg[1] <= pos_reg[1] + 32'd1;
                    off_reg[1] <= off_reg[1] + 1'b1;
                end
                else
                begin
                    pos_reg[1] <= lo_reg[1];
                    off_reg[1] <= '0;
                    pos_reg[0] <= pos_reg[0] + 32'd1;
                    off_reg[0] <= off_reg[0] + 1'b1;
                end
            end
        end
    end

    // sign-extended index times 32-bit prime, low 64 bits
    assign px_full = $signed({pos_reg[0][31], pos_reg[0]}) * $signed({1'b0, HASH_PX});
    assign py_full = $signed({pos_reg[1][31], pos_reg[1]}) * $signed({1'b0, HASH_PY});
    assign pz_full = $signed({pos_reg[2][31], pos_reg[2]}) * $signed({1'b0, HASH_PZ});
    assign mx = px_full[63:0];
    assign my = py_full[63:0];
    assign mz = pz_full[63:0];

    always_ff @(posedge clk)
    begin
        if (hph_reg == 2'd1)
        begin
            prod_reg[0] <= mx;
            prod_reg[1] <= my;
            prod_reg[2] <= mz;
        end
        if (hph_reg == 2'd2)
            cell_key <= prod_reg[0] ^ prod_reg[1] ^ prod_reg[2];
    end

    assign cell_x  = pos_reg[0];
    assign cell_y  = pos_reg[1];
    assign cell_z  = pos_reg[2];
    assign clipped = clip_reg;

    assign stat.div_done  = run_reg && ddone && idx_reg == 3'd5;
    assign stat.empty     = empty_c;
    assign stat.hash_done = hdone_reg;
    assign stat.last      = end_x && end_y && end_z;
endmodule

FILE: src/gcke_ctrl.sv
`timescale 1ns / 1ps
module gcke_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_fire,
    input  gcke_pkg::stat_t stat,
    output gcke_pkg::ctrl_t ctrl,
    output logic            in_ready,
    output logic            out_valid
);
    import gcke_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_DIV;
            ST_DIV:   if (stat.div_done) state_next = ST_CHECK;
            ST_CHECK: state_next = stat.empty ? ST_IDLE : ST_HASH;
            ST_HASH:  if (stat.hash_done) state_next = ST_EMIT;
            ST_EMIT:  if (out_fire) state_next = stat.last ? ST_IDLE : ST_HASH;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                ctrl.load      = in_fire;
                ctrl.div_start = in_fire;
            end
            ST_DIV:   ;
            ST_CHECK:
            begin
                ctrl.bounds_latch = !stat.empty;
                ctrl.hash_start   = !stat.empty;
            end
            ST_HASH:  ;
            ST_EMIT:
            begin
                out_valid       = 1'b1;
                ctrl.advance    = out_fire && !stat.last;
                ctrl.hash_start = out_fire && !stat.last;
            end
            default:  ;
        endcase
    end
endmodule

FILE: src/grid_cell_key_enumerator.sv
`timescale 1ns / 1ps
// grid_cell_key_enumerator
// Slave channel s_axis_*: one request per bounding box; tdata holds min_x,
// min_y, min_z, max_x, max_y, max_z from the lowest bit up (32 bits each,
// signed Q16.16).
// Master channel m_axis_*: one result per cell, x outermost, z innermost;
// tdata holds cell_key, cell_x, cell_y, cell_z from the lowest bit up, tuser
// carries span_clipped and tlast marks the final cell of a box.
// pitch_we / pitch_wdata write the cell edge (Q16.16); zero acts as a raw 1.
// Write it only while idle.
// Sequence: six floor divisions through one bit-serial divider, a check
// state, then each key is formed by registering the three products and
// then their XOR; each further key starts when the previous result is
// taken. A box yields 0..64 results; the next request is taken the cycle
// after the last result is delivered, or once the check finds a box with
// no cells.
// Reset returns the walk to idle and the cell edge to 1.0.
// A stalled receiver holds the current result steady; the walk waits.
module grid_cell_key_enumerator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pitch_we,
    input  logic [30:0]   pitch_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [191:0]  s_axis_tdata,  // min_x, min_y, min_z, max_x, max_y, max_z
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [159:0]  m_axis_tdata,  // cell_key, cell_x, cell_y, cell_z
    output logic          m_axis_tuser,  // span_clipped
    output logic          m_axis_tlast
);
    import gcke_pkg::*;

    logic [30:0] pitch_reg;
    ctrl_t ctrl;
    stat_t stat;
    logic [63:0] key;
    logic [31:0] cx, cy, cz;
    logic clip;
    logic in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pitch_reg <= 31'd65536;
        else if (pitch_we)
            pitch_reg <= pitch_wdata;
    end

    gcke_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .box(s_axis_tdata), .pitch(pitch_reg),
        .cell_key(key), .cell_x(cx), .cell_y(cy), .cell_z(cz), .clipped(clip)
    );

    gcke_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .stat(stat), .ctrl(ctrl), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    assign m_axis_tdata = {cz, cy, cx, key};
    assign m_axis_tuser = clip;
    assign m_axis_tlast = stat.last;

`ifndef SYNTH
    // never accept a box while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken mid-walk");
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("result changed under stall");
`endif
endmodule

FILE: dv/grid_cell_key_enumerator_checker.sv
`timescale 1ns / 1ps
module grid_cell_key_enumerator_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pitch_we,
    input  logic [30:0]    pitch_wdata,
    input  logic           s_axis_tvalid,
    input  logic           s_axis_tready,
    input  logic [191:0]   s_axis_tdata,
    input  logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    input  logic [159:0]   m_axis_tdata,
    input  logic           m_axis_tuser,
    input  logic           m_axis_tlast,
    output int             mismatches,
    output int             keys_pending
);
    import gcke_pkg::*;

    typedef struct {
        logic [KEY_W-1:0]   key;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic               last;
        logic               clipped;
    } cell_rec_t;

    cell_rec_t       expected_cells[$];
    logic [30:0]     edge_len;

    assign keys_pending = expected_cells.size();

    function automatic longint cell_index(logic [31:0] coord, longint d);
        longint a;
        longint q;
        a = longint'($signed(coord));
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [63:0] hash_of(longint x, longint y, longint z);
        logic [63:0] hx;
        logic [63:0] hy;
        logic [63:0] hz;
        hx = 64'(x) * 64'(HASH_PX);
        hy = 64'(y) * 64'(HASH_PY);
        hz = 64'(z) * 64'(HASH_PZ);
        return hx ^ hy ^ hz;
    endfunction

    // Expand one box request into its cell walk, x outermost, z innermost.
    task automatic enumerate_cells(logic [191:0] box);
        longint    d;
        longint    lo[3];
        longint    hi[3];
        logic      clip;
        cell_rec_t c;
        d = (edge_len == 0) ? 1 : longint'(edge_len);
        clip = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = cell_index(box[32*a +: 32], d);
            hi[a] = cell_index(box[32*(a+3) +: 32], d);
            if (hi[a] < lo[a])
                return;
            if (hi[a] - lo[a] + 1 > MAX_SPAN)
            begin
                hi[a] = lo[a] + MAX_SPAN - 1;
                clip = 1'b1;
            end
        end
        for (longint x = lo[0]; x <= hi[0]; x++)
            for (longint y = lo[1]; y <= hi[1]; y++)
                for (longint z = lo[2]; z <= hi[2]; z++)
                begin
                    c.key     = hash_of(x, y, z);
                    c.cx      = x[31:0];
                    c.cy      = y[31:0];
                    c.cz      = z[31:0];
                    c.last    = (x == hi[0]) && (y == hi[1]) && (z == hi[2]);
                    c.clipped = clip;
                    expected_cells = {expected_cells, c};
                end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin
        cell_rec_t c;
        if (!rst_n)
        begin
            edge_len = 31'd65536;
            expected_cells.delete();
        end
        else
        begin
            if (pitch_we)
                edge_len = pitch_wdata;
            if (s_axis_tvalid && s_axis_tready)
                enumerate_cells(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_cells.size() == 0)
                    report("unexpected cell", m_axis_tdata[63:0], 64'd0);
                else
                begin
                    c = expected_cells.pop_front();
                    if (m_axis_tdata[63:0] !== c.key)
                        report("cell_key", m_axis_tdata[63:0], c.key);
                    if (m_axis_tdata[95:64] !== c.cx)
                        report("cell_x", 64'(m_axis_tdata[95:64]), 64'(c.cx));
                    if (m_axis_tdata[127:96] !== c.cy)
                        report("cell_y", 64'(m_axis_tdata[127:96]), 64'(c.cy));
                    if (m_axis_tdata[159:128] !== c.cz)
                        report("cell_z", 64'(m_axis_tdata[159:128]), 64'(c.cz));
                    if (m_axis_tlast !== c.last)
                        report("last_cell", 64'(m_axis_tlast), 64'(c.last));
                    if (m_axis_tuser !== c.clipped)
                        report("span_clipped", 64'(m_axis_tuser), 64'(c.clipped));
                end
            end
        end
    end
endmodule

FILE: dv/grid_cell_key_enumerator_tb.sv
`timescale 1ns / 1ps
module grid_cell_key_enumerator_tb;
    import gcke_pkg::*;

    // Worst box: six divisions plus 64 keys, each possibly held by receiver stalls.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 400;
    localparam int RAND_ITEMS  = 54;

    logic          clk;
    logic          rst_n;
    logic          pitch_we;
    logic [30:0]   pitch_wdata;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [191:0]  s_axis_tdata;   // min_x, min_y, min_z, max_x, max_y, max_z
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [159:0]  m_axis_tdata;   // cell_key, cell_x, cell_y, cell_z
    logic          m_axis_tuser;   // span_clipped
    logic          m_axis_tlast;

    int            mismatches;
    int            keys_pending;
    int            cycles;
    logic          quiet;          // no idling on either side when set
    int            ready_hold;
    logic [30:0]   cur_edge;

    grid_cell_key_enumerator DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .pitch_we        (pitch_we),
        .pitch_wdata     (pitch_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast)
    );

    grid_cell_key_enumerator_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .pitch_we        (pitch_we),
        .pitch_wdata     (pitch_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .mismatches      (mismatches),
        .keys_pending    (keys_pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver side: drop ready for random bursts, hold it high when quiet.
    always @(posedge clk)
    begin
        if (quiet)
            m_axis_tready <= 1'b1;
        else if (ready_hold > 0)
        begin
            ready_hold    <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            ready_hold    <= $urandom_range(1, 14) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Send one box request; hold valid until accepted, then maybe idle.
    task automatic send_box(logic [31:0] mn [3], logic [31:0] mx [3]);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mx[2], mx[1], mx[0], mn[2], mn[1], mn[0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Build a box for the current cell edge: mostly a few cells per axis,
    // some empty axes, some over-wide spans, some raw noise.
    task automatic random_box();
        logic [31:0] mn [3];
        logic [31:0] mx [3];
        longint      d;
        longint      lo;
        int          mode;
        d = (cur_edge == 0) ? 1 : longint'(cur_edge);
        mode = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++)
        begin
            mn[a] = $urandom;
            lo = longint'($signed(mn[a]));
            if (mode == 0)
                mx[a] = $urandom;
            else if (mode == 1 && a == $urandom_range(0, 2))
                mx[a] = clamp32(lo - d * $urandom_range(1, 2));
            else if (mode == 2)
                mx[a] = clamp32(lo + d * $urandom_range(4, 9));
            else
                mx[a] = clamp32(lo + d * $urandom_range(0, 3)
                                + longint'($urandom_range(0, 31'(d - 1))));
        end
        send_box(mn, mx);
    endtask

    task automatic directed_box(int a0, int a1, int a2, int b0, int b1, int b2);
        logic [31:0] mn [3];
        logic [31:0] mx [3];
        mn = '{a0, a1, a2};
        mx = '{b0, b1, b2};
        send_box(mn, mx);
    endtask

    // Drain everything, let an empty box finish, then write the cell edge.
    task automatic set_edge(logic [30:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (keys_pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        pitch_we    <= 1'b1;
        pitch_wdata <= v;
        cur_edge    <= v;
        @(posedge clk);
        pitch_we    <= 1'b0;
    endtask

    initial
    begin
        logic [30:0] edges [6];
        rst_n           = 1'b0;
        pitch_we        = 1'b0;
        pitch_wdata     = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        quiet           = 1'b0;
        ready_hold      = 0;
        cycles          = 0;
        cur_edge        = 31'd65536;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset edge of 1.0.
        directed_box(0, 0, 0, 0, 0, 0);
        directed_box(-32'sd2147483648, -32'sd2147483648, -32'sd2147483648,
                     32'sd2147483647, 32'sd2147483647, 32'sd2147483647);
        directed_box(32'sd2147483647, 32'sd2147483647, 32'sd2147483647,
                     32'sd2147483647, 32'sd2147483647, 32'sd2147483647);
        directed_box(-32'sd2147483648, 0, 0, -32'sd2147483648, 0, 0);
        // Empty axis in each position.
        directed_box(65536, 0, 0, 0, 0, 0);
        directed_box(0, 65536, 0, 0, 0, 0);
        directed_box(0, 0, 65536, 0, 0, 0);
        // Negative coordinates floor toward minus infinity.
        directed_box(-1, -65536, -65537, 0, -65535, -65536);
        // Exactly four cells, then five (clipped).
        directed_box(0, 0, 0, 4*65536-1, 0, 0);
        directed_box(0, 0, 0, 0, 0, 5*65536-1);
        directed_box(-131072, -131072, -131072, 131071, 131071, 131071);
        directed_box(100, 200, 300, 65535, 65535, 65535);

        edges = '{31'd1, 31'd0, 31'h7fff_ffff, 31'd65536, 31'd3, 31'd0};
        edges[5] = 31'($urandom_range(2, 31'h7fff_ffff));
        for (int p = 0; p < 6; p++)
        begin
            set_edge(edges[p]);
            if (p == 0)
            begin
                // Zero-width and wide spans at the smallest edge.
                directed_box(-5, -5, -5, -5, -5, -5);
                directed_box(0, 0, 0, 100, 100, 100);
            end
            if (p == 5)
                quiet <= 1'b1;
            for (int i = 0; i < RAND_ITEMS; i++)
                random_box();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (keys_pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && keys_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
